// File: design/swlap_pkg.sv
// Shared types and constants for the stopwatch with lap memory.
// No dependencies; the other design files that use it refer to it by scoped names.
package swlap_pkg;

  localparam int unsigned MIN_W  = 7;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned CEN_W  = 7;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned LAP_W  = MIN_W + SEC_W + CEN_W;

  localparam logic [CEN_W-1:0] CEN_LAST = CEN_W'(99);
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(59);
  localparam logic [MIN_W-1:0] MIN_LAST = MIN_W'(99);

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_RESET = 3'd3,
    CMD_LAP   = 3'd4,
    CMD_UP    = 3'd5,
    CMD_DOWN  = 3'd6,
    CMD_READ  = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] row_offset;
  } in_item_t;

  typedef struct packed {
    logic [MIN_W-1:0] time_minutes;
    logic [SEC_W-1:0] time_seconds;
    logic [CEN_W-1:0] time_centis;
    logic             is_running;
    logic [CNT_W-1:0] laps_stored;
    logic [CNT_W-1:0] scroll_pos;
    logic             row_valid;
    logic [CNT_W-1:0] row_lap_number;
    logic [MIN_W-1:0] row_minutes;
    logic [SEC_W-1:0] row_seconds;
    logic [CEN_W-1:0] row_centis;
  } out_item_t;

  // Item state handed from the update stage to the read-out stage
  typedef struct packed {
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic [CEN_W-1:0] centis;
    logic             running;
    logic [CNT_W-1:0] laps;
    logic [CNT_W-1:0] scroll;
    logic             row_valid;
    logic [CNT_W-1:0] row_num;
    logic             fwd;
    logic [LAP_W-1:0] fwd_data;
  } stage_t;

endpackage

// File: design/swlap_stream_if.sv
// Valid/ready stream interface carrying one item of payload type T.
// Depends on nothing; payload types come from swlap_pkg at instantiation.
interface swlap_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/stopwatch_with_lap_memory.sv
// Stopwatch with lap memory, top level. Depends on swlap_pkg, swlap_stream_if,
// swlap_ram, swlap_ctrl and swlap_rdout.
// An accepted command is registered with its read of the one-write, one-read lap
// store, then moved to the output register; one item per cycle unless res_o stalls.
// Reset: counters, run flag, lap count, scroll and valids clear; lap store is
// not cleared, only entries below the lap count are ever used.
module stopwatch_with_lap_memory #(
  parameter int unsigned LAP_DEPTH = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  swlap_stream_if.sink   cmd_i,
  swlap_stream_if.source res_o
);

  localparam int unsigned IW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;

  logic                        acc;
  logic                        take;
  logic                        we;
  logic [IW-1:0]               waddr;
  logic [IW-1:0]               raddr;
  logic [swlap_pkg::LAP_W-1:0] wdata;
  logic [swlap_pkg::LAP_W-1:0] rdata;
  swlap_pkg::stage_t           stage;

  assign cmd_i.ready = take;
  assign acc         = cmd_i.valid && take;

  swlap_ctrl #(.LAP_DEPTH(LAP_DEPTH)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .item_i  (cmd_i.data),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .raddr_o (raddr),
    .stage_o (stage)
  );

  swlap_ram #(.WIDTH(swlap_pkg::LAP_W), .DEPTH(LAP_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we && acc),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (acc),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  swlap_rdout u_rdout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .stage_i     (stage),
    .rdata_i     (rdata),
    .take_o      (take),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res_o.data)
  );

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input stalled without output backpressure");

  a_scroll_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && LAP_DEPTH < 16) |->
      ((res_o.data.laps_stored == '0 && res_o.data.scroll_pos == '0) ||
       (res_o.data.scroll_pos < res_o.data.laps_stored)))
    else $error("scroll position outside stored laps");

  a_invalid_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.data.row_valid) |->
      (res_o.data.row_lap_number == '0 && res_o.data.row_minutes == '0 &&
       res_o.data.row_seconds == '0 && res_o.data.row_centis == '0))
    else $error("invalid row carries lap data");

endmodule

// File: design/swlap_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
module swlap_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 10
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/swlap_ctrl.sv
// Command decode, time counters, lap count and scroll registers; issues lap
// store write and row read. Depends on swlap_pkg.
module swlap_ctrl #(
  parameter int unsigned LAP_DEPTH = 10
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             acc_i,
  input  swlap_pkg::in_item_t                              item_i,
  output logic                                             we_o,
  output logic [((LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1)-1:0] waddr_o,
  output logic [swlap_pkg::LAP_W-1:0]                      wdata_o,
  output logic [((LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1)-1:0] raddr_o,
  output swlap_pkg::stage_t                                stage_o
);

  localparam int unsigned CW = $clog2(LAP_DEPTH + 1);
  localparam int unsigned IW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
  localparam int unsigned SW = (CW > 2) ? CW : 2;

  logic [swlap_pkg::CEN_W-1:0] cen_q, cen_d;
  logic [swlap_pkg::SEC_W-1:0] sec_q, sec_d;
  logic [swlap_pkg::MIN_W-1:0] min_q, min_d;
  logic                        run_q, run_d;
  logic [CW-1:0]               total_q, total_d;
  logic [CW-1:0]               scroll_q, scroll_d;

  logic [SW:0]                 diff;
  logic [SW:0]                 num;
  logic                        row_ok;

  always_comb begin
    cen_d    = cen_q;
    sec_d    = sec_q;
    min_d    = min_q;
    run_d    = run_q;
    total_d  = total_q;
    scroll_d = scroll_q;
    we_o     = 1'b0;
    unique case (swlap_pkg::cmd_e'(item_i.cmd))
      swlap_pkg::CMD_TICK: begin
        if (run_q) begin
          if (cen_q == swlap_pkg::CEN_LAST) begin
            cen_d = '0;
            if (sec_q == swlap_pkg::SEC_LAST) begin
              sec_d = '0;
              min_d = (min_q == swlap_pkg::MIN_LAST) ? '0 : min_q + 1'b1;
            end else begin
              sec_d = sec_q + 1'b1;
            end
          end else begin
            cen_d = cen_q + 1'b1;
          end
        end
      end
      swlap_pkg::CMD_START: run_d = 1'b1;
      swlap_pkg::CMD_STOP:  run_d = 1'b0;
      swlap_pkg::CMD_RESET: begin
        cen_d    = '0;
        sec_d    = '0;
        min_d    = '0;
        run_d    = 1'b0;
        total_d  = '0;
        scroll_d = '0;
      end
      swlap_pkg::CMD_LAP: begin
        if (run_q) begin
          if (total_q != CW'(LAP_DEPTH)) begin
            we_o     = 1'b1;
            total_d  = total_q + 1'b1;
            scroll_d = total_q;
          end else begin
            scroll_d = total_q - 1'b1;
          end
        end
      end
      swlap_pkg::CMD_UP: begin
        if (total_q != '0 && scroll_q < total_q - 1'b1) begin
          scroll_d = scroll_q + 1'b1;
        end
      end
      swlap_pkg::CMD_DOWN: begin
        if (scroll_q != '0) begin
          scroll_d = scroll_q - 1'b1;
        end
      end
      swlap_pkg::CMD_READ: ;
      default: ;
    endcase
  end

  // Row index = scroll - offset; the top bit is the borrow
  always_comb begin
    diff   = {1'b0, SW'(scroll_d)} - {1'b0, SW'(item_i.row_offset)};
    row_ok = !diff[SW] && (diff[SW-1:0] < SW'(total_d));
    num    = {1'b0, diff[SW-1:0]} + 1'b1;
  end

  assign waddr_o = IW'(total_q);
  assign wdata_o = {min_q, sec_q, cen_q};
  assign raddr_o = IW'(diff[SW-1:0]);

  always_comb begin
    stage_o.minutes   = min_d;
    stage_o.seconds   = sec_d;
    stage_o.centis    = cen_d;
    stage_o.running   = run_d;
    stage_o.laps      = swlap_pkg::CNT_W'(total_d);
    stage_o.scroll    = swlap_pkg::CNT_W'(scroll_d);
    stage_o.row_valid = row_ok;
    stage_o.row_num   = row_ok ? swlap_pkg::CNT_W'(num) : '0;
    stage_o.fwd       = we_o && (waddr_o == raddr_o);
    stage_o.fwd_data  = wdata_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q    <= '0;
      sec_q    <= '0;
      min_q    <= '0;
      run_q    <= 1'b0;
      total_q  <= '0;
      scroll_q <= '0;
    end else if (acc_i) begin
      cen_q    <= cen_d;
      sec_q    <= sec_d;
      min_q    <= min_d;
      run_q    <= run_d;
      total_q  <= total_d;
      scroll_q <= scroll_d;
    end
  end

endmodule

// File: design/swlap_rdout.sv
// Read-out stage: waits for lap store data, forwards a same-cycle write,
// and holds the result item in an output register. Depends on swlap_pkg.
module swlap_rdout (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  swlap_pkg::stage_t           stage_i,
  input  logic [swlap_pkg::LAP_W-1:0] rdata_i,
  output logic                        take_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output swlap_pkg::out_item_t        out_data_o
);

  swlap_pkg::stage_t    s1_q;
  logic                 s1_v_q, s1_v_d;
  logic                 out_v_q, out_v_d;
  logic                 s1_adv;
  logic [swlap_pkg::LAP_W-1:0] lap;
  swlap_pkg::out_item_t res_d;

  assign s1_adv  = s1_v_q && (!out_v_q || out_ready_i);
  assign take_o  = !s1_v_q || s1_adv;
  assign s1_v_d  = acc_i || (s1_v_q && !s1_adv);
  assign out_v_d = s1_adv || (out_v_q && !out_ready_i);

  always_comb begin
    lap = s1_q.fwd ? s1_q.fwd_data : rdata_i;
    if (!s1_q.row_valid) begin
      lap = '0;
    end
    res_d.time_minutes   = s1_q.minutes;
    res_d.time_seconds   = s1_q.seconds;
    res_d.time_centis    = s1_q.centis;
    res_d.is_running     = s1_q.running;
    res_d.laps_stored    = s1_q.laps;
    res_d.scroll_pos     = s1_q.scroll;
    res_d.row_valid      = s1_q.row_valid;
    res_d.row_lap_number = s1_q.row_num;
    {res_d.row_minutes, res_d.row_seconds, res_d.row_centis} = lap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= stage_i;
    end
    if (s1_adv) begin
      out_data_o <= res_d;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

// File: tb/sv/stopwatch_with_lap_memory_test.sv
// Self-checking testbench for stopwatch_with_lap_memory: commands go in over a
// valid/ready stream and each result is checked against an in-bench predictor.
// Depends on swlap_pkg, swlap_stream_if and the stopwatch_with_lap_memory RTL.
module stopwatch_with_lap_memory_test;

  localparam int unsigned DEPTH      = 10;
  localparam int unsigned IW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct {
    logic [swlap_pkg::MIN_W-1:0] mins;
    logic [swlap_pkg::SEC_W-1:0] secs;
    logic [swlap_pkg::CEN_W-1:0] cents;
  } lap_rec_t;

  logic clk_i;
  logic rst_ni;

  swlap_stream_if #(.T(swlap_pkg::in_item_t))  cmd_if ();
  swlap_stream_if #(.T(swlap_pkg::out_item_t)) res_if ();

  stopwatch_with_lap_memory #(.LAP_DEPTH(DEPTH)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // predicted watch state
  logic [swlap_pkg::MIN_W-1:0] w_min     = '0;
  logic [swlap_pkg::SEC_W-1:0] w_sec     = '0;
  logic [swlap_pkg::CEN_W-1:0] w_cen     = '0;
  logic                        w_run     = 1'b0;
  logic [swlap_pkg::CNT_W-1:0] laps_held = '0;
  logic [swlap_pkg::CNT_W-1:0] scroll_at = '0;
  lap_rec_t                    lap_log [DEPTH];

  swlap_pkg::out_item_t pending_results [$];

  int   mismatch_cnt = 0;
  int   idle_cycles  = 0;
  bit   gaps_on      = 1'b0;
  int   burst_left   = 0;
  bit   rx_stalls_on = 1'b0;
  logic [15:0] stall_pat = '1;
  int   pat_age      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic swlap_pkg::out_item_t predict_display(swlap_pkg::cmd_e c,
                                                           logic [1:0] off);
    swlap_pkg::out_item_t r;
    int                   idx;
    logic                 hit;
    case (c)
      swlap_pkg::CMD_TICK: begin
        if (w_run) begin
          if (w_cen == swlap_pkg::CEN_LAST) begin
            w_cen = '0;
            if (w_sec == swlap_pkg::SEC_LAST) begin
              w_sec = '0;
              w_min = (w_min == swlap_pkg::MIN_LAST) ? '0 : w_min + 1'b1;
            end else begin
              w_sec = w_sec + 1'b1;
            end
          end else begin
            w_cen = w_cen + 1'b1;
          end
        end
      end
      swlap_pkg::CMD_START: w_run = 1'b1;
      swlap_pkg::CMD_STOP:  w_run = 1'b0;
      swlap_pkg::CMD_RESET: begin
        w_min     = '0;
        w_sec     = '0;
        w_cen     = '0;
        w_run     = 1'b0;
        laps_held = '0;
        scroll_at = '0;
      end
      swlap_pkg::CMD_LAP: begin
        if (w_run) begin
          if (laps_held < swlap_pkg::CNT_W'(DEPTH)) begin
            lap_log[IW'(laps_held)] = '{mins: w_min, secs: w_sec, cents: w_cen};
            laps_held = laps_held + 1'b1;
          end
          scroll_at = laps_held - 1'b1;
        end
      end
      swlap_pkg::CMD_UP: begin
        if (laps_held != '0 && scroll_at < laps_held - 1'b1) scroll_at = scroll_at + 1'b1;
      end
      swlap_pkg::CMD_DOWN: begin
        if (scroll_at != '0) scroll_at = scroll_at - 1'b1;
      end
      default: ;
    endcase

    idx = int'(scroll_at) - int'(off);
    hit = (idx >= 0) && (idx < int'(laps_held)) && (idx < int'(DEPTH));

    r = '0;
    r.time_minutes = w_min;
    r.time_seconds = w_sec;
    r.time_centis  = w_cen;
    r.is_running   = w_run;
    r.laps_stored  = laps_held;
    r.scroll_pos   = scroll_at;
    r.row_valid    = hit;
    if (hit) begin
      r.row_lap_number = swlap_pkg::CNT_W'(idx + 1);
      r.row_minutes    = lap_log[IW'(idx)].mins;
      r.row_seconds    = lap_log[IW'(idx)].secs;
      r.row_centis     = lap_log[IW'(idx)].cents;
    end
    return r;
  endfunction

  task automatic issue_cmd(input swlap_pkg::cmd_e c, input logic [1:0] off);
    if (gaps_on && burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= '{cmd: c, row_offset: off};
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_results.push_back(predict_display(c, off));
  endtask

  task automatic check_field(input string name, input logic [6:0] exp_v,
                             input logic [6:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_result(input swlap_pkg::out_item_t e, input swlap_pkg::out_item_t a);
    check_field("time_minutes",   e.time_minutes,       a.time_minutes);
    check_field("time_seconds",   7'(e.time_seconds),   7'(a.time_seconds));
    check_field("time_centis",    e.time_centis,        a.time_centis);
    check_field("is_running",     7'(e.is_running),     7'(a.is_running));
    check_field("laps_stored",    7'(e.laps_stored),    7'(a.laps_stored));
    check_field("scroll_pos",     7'(e.scroll_pos),     7'(a.scroll_pos));
    check_field("row_valid",      7'(e.row_valid),      7'(a.row_valid));
    check_field("row_lap_number", 7'(e.row_lap_number), 7'(a.row_lap_number));
    check_field("row_minutes",    e.row_minutes,        a.row_minutes);
    check_field("row_seconds",    7'(e.row_seconds),    7'(a.row_seconds));
    check_field("row_centis",     e.row_centis,         a.row_centis);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result expected none actual %p", $time, res_if.data);
      end else begin
        check_result(pending_results.pop_front(), res_if.data);
      end
    end
  end

  // result-side backpressure: a rotating random stall pattern, redrawn now and then
  always @(posedge clk_i) begin
    if (pat_age == 0) begin
      stall_pat = 16'($urandom());
      stall_pat[4'($urandom_range(0, 15))] = 1'b1;
      pat_age = 64;
    end
    pat_age--;
    stall_pat = {stall_pat[0], stall_pat[15:1]};
    res_if.ready <= !rx_stalls_on || stall_pat[0];
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_directed();
    gaps_on      = 1'b1;
    rx_stalls_on = 1'b1;
    issue_cmd(swlap_pkg::CMD_READ, 2'd0);
    issue_cmd(swlap_pkg::CMD_READ, 2'd3);
    issue_cmd(swlap_pkg::CMD_UP, 2'd0);
    issue_cmd(swlap_pkg::CMD_DOWN, 2'd1);
    issue_cmd(swlap_pkg::CMD_LAP, 2'd0);
    issue_cmd(swlap_pkg::CMD_TICK, 2'd0);
    issue_cmd(swlap_pkg::CMD_STOP, 2'd2);
    issue_cmd(swlap_pkg::CMD_START, 2'd0);
    issue_cmd(swlap_pkg::CMD_START, 2'd1);
    repeat (3) issue_cmd(swlap_pkg::CMD_TICK, 2'd0);
    issue_cmd(swlap_pkg::CMD_LAP, 2'd0);
    issue_cmd(swlap_pkg::CMD_TICK, 2'd1);
    issue_cmd(swlap_pkg::CMD_LAP, 2'd1);
    issue_cmd(swlap_pkg::CMD_LAP, 2'd2);
    issue_cmd(swlap_pkg::CMD_UP, 2'd0);
    issue_cmd(swlap_pkg::CMD_DOWN, 2'd0);
    issue_cmd(swlap_pkg::CMD_DOWN, 2'd3);
    issue_cmd(swlap_pkg::CMD_DOWN, 2'd0);
    issue_cmd(swlap_pkg::CMD_UP, 2'd1);
    issue_cmd(swlap_pkg::CMD_READ, 2'd3);
    issue_cmd(swlap_pkg::CMD_STOP, 2'd0);
    issue_cmd(swlap_pkg::CMD_TICK, 2'd0);
    issue_cmd(swlap_pkg::CMD_RESET, 2'd0);
    issue_cmd(swlap_pkg::CMD_READ, 2'd2);
  endtask

  task automatic test_full_store();
    gaps_on      = 1'b0;
    rx_stalls_on = 1'b1;
    issue_cmd(swlap_pkg::CMD_START, 2'd0);
    for (int i = 0; i < DEPTH + 2; i++) begin
      repeat ($urandom_range(1, 9)) issue_cmd(swlap_pkg::CMD_TICK, 2'($urandom_range(0, 3)));
      issue_cmd(swlap_pkg::CMD_LAP, 2'($urandom_range(0, 3)));
    end
    repeat (DEPTH + 1) issue_cmd(swlap_pkg::CMD_DOWN, 2'($urandom_range(0, 3)));
    repeat (3) issue_cmd(swlap_pkg::CMD_UP, 2'($urandom_range(0, 3)));
    issue_cmd(swlap_pkg::CMD_LAP, 2'd1);
    issue_cmd(swlap_pkg::CMD_UP, 2'd0);
    for (int o = 0; o < 4; o++) issue_cmd(swlap_pkg::CMD_READ, 2'(o));
    issue_cmd(swlap_pkg::CMD_STOP, 2'd0);
    issue_cmd(swlap_pkg::CMD_RESET, 2'd0);
  endtask

  // runs the centiseconds through two carries into seconds, with laps on the way
  task automatic test_second_carry();
    gaps_on      = 1'b0;
    rx_stalls_on = 1'b0;
    issue_cmd(swlap_pkg::CMD_RESET, 2'd0);
    issue_cmd(swlap_pkg::CMD_START, 2'd0);
    for (int n = 1; n < 205; n++) begin
      issue_cmd(swlap_pkg::CMD_TICK, 2'($urandom_range(0, 3)));
      if (n % 50 == 0) issue_cmd(swlap_pkg::CMD_LAP, 2'($urandom_range(0, 3)));
    end
    issue_cmd(swlap_pkg::CMD_LAP, 2'd0);
    issue_cmd(swlap_pkg::CMD_TICK, 2'd0);
    issue_cmd(swlap_pkg::CMD_DOWN, 2'd2);
    issue_cmd(swlap_pkg::CMD_LAP, 2'd0);
    for (int o = 0; o < 4; o++) issue_cmd(swlap_pkg::CMD_READ, 2'(o));
  endtask

  task automatic test_random();
    int              r;
    swlap_pkg::cmd_e c;
    issue_cmd(swlap_pkg::CMD_RESET, 2'd0);
    issue_cmd(swlap_pkg::CMD_START, 2'd0);
    for (int chunk = 0; chunk < 6; chunk++) begin
      gaps_on      = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      repeat (100) begin
        r = $urandom_range(0, 99);
        if      (r < 40) c = swlap_pkg::CMD_TICK;
        else if (r < 52) c = swlap_pkg::CMD_LAP;
        else if (r < 62) c = swlap_pkg::CMD_UP;
        else if (r < 72) c = swlap_pkg::CMD_DOWN;
        else if (r < 80) c = swlap_pkg::CMD_READ;
        else if (r < 88) c = swlap_pkg::CMD_START;
        else if (r < 95) c = swlap_pkg::CMD_STOP;
        else if (r < 97) c = swlap_pkg::CMD_RESET;
        else             c = swlap_pkg::CMD_TICK;
        issue_cmd(c, 2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    res_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_store();
    test_second_carry();
    test_random();

    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/swlap_pkg.sv
design/swlap_stream_if.sv
design/swlap_ram.sv
design/swlap_ctrl.sv
design/swlap_rdout.sv
design/stopwatch_with_lap_memory.sv
tb/sv/stopwatch_with_lap_memory_test.sv
